### src/serial_line_editor_assert.svh
// assertion helpers for the serial line editor
// all of them sample on clock and are held off while reset is high
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sle_pkg.sv
package sle_pkg;

   localparam int LINE_CAPACITY = 128;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

   localparam int PREFIX_LEN    = 9;
   localparam int CMD_LEN       = 9;
   localparam int MSG_MAX       = PREFIX_LEN + LINE_CAPACITY + 1;
   localparam int POS_W         = $clog2(MSG_MAX + 1);
   localparam int CHUNK_BYTES   = 8;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_BS        = 8'd8;
   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_DEL       = 8'd127;
   localparam logic [7:0] CHAR_PRINT_MIN = 8'd32;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_MSG  = 2'd1;
   localparam logic [1:0] KIND_CMD  = 2'd2;

   typedef enum logic [1:0] {
      OP_PUT,
      OP_ERASE,
      OP_EOL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // "[serial] "
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0: c = 8'h5B;
         4'd1: c = 8'h73;
         4'd2: c = 8'h65;
         4'd3: c = 8'h72;
         4'd4: c = 8'h69;
         4'd5: c = 8'h61;
         4'd6: c = 8'h6C;
         4'd7: c = 8'h5D;
         4'd8: c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "/deadlock"
   function automatic logic [7:0] cmd_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0: c = 8'h2F;
         4'd1: c = 8'h64;
         4'd2: c = 8'h65;
         4'd3: c = 8'h61;
         4'd4: c = 8'h64;
         4'd5: c = 8'h6C;
         4'd6: c = 8'h6F;
         4'd7: c = 8'h63;
         4'd8: c = 8'h6B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### src/serial_line_editor.sv
// channel   dir   handshake               payload
// req       in    req_valid / req_stall   req_rx_byte
// rsp       out   rsp_valid / rsp_stall   rsp_out_bytes, rsp_out_count, rsp_out_kind,
//                                         rsp_out_last
//
// a printable byte or an erase goes through front, queue and back
// end of line: echo, then the message in chunks of up to eight bytes, gathered through the
// single read port of the line ram (one byte a cycle while gathering, plus load and hand-off)
// a full line holds 128 bytes; "/deadlock" adds a check of the line before any result
// reset is synchronous, active high; line ram needs no clearing pass
// rsp_stall holds the output register; the front keeps taking items until the queue is full
`include "serial_line_editor_assert.svh"

module serial_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_out_count,
   output logic [1:0]  rsp_out_kind,
   output logic        rsp_out_last
);
   import sle_pkg::*;

   // front to queue
   logic             q_push;
   item_type         q_item;
   // queue to back
   logic             q_pop;
   item_type         pop_item;
   queue_status_type q_status;

   // front: takes bytes, drops plain control codes, tags put / erase / end of line
   sle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   // short queue so the front does not wait on a stalled result until the queue is full
   sle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // back: owns the line store, the length and the result register
   sle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_item      (pop_item),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_bytes (rsp_out_bytes),
      .rsp_out_count (rsp_out_count),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_last  (rsp_out_last)
   );

   // front only pushes into a queue with room
   `SLE_ASSERT_NOW(a_push_room, q_push, !q_status.full, "push into full queue")
   // back only pops a queue that holds an item
   `SLE_ASSERT_NOW(a_pop_item, q_pop, !q_status.empty, "pop from empty queue")
   // the command result carries no bytes and closes its item
   `SLE_ASSERT_NOW(a_cmd_shape, rsp_valid && rsp_out_kind == KIND_CMD,
      rsp_out_count == 4'd0 && rsp_out_last, "bad command result")
   // an end of line shows its CR LF echo right after it leaves the queue
   `SLE_ASSERT_NEXT(a_eol_echo, q_pop && pop_item.op == OP_EOL,
      rsp_valid && rsp_out_kind == KIND_ECHO && rsp_out_count == 4'd2, "missing line echo")

endmodule

### src/sle_ram.sv
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sle_front.sv
module sle_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  sle_pkg::queue_status_type q_status,
   output logic                      q_push,
   output sle_pkg::item_type         q_item
);
   import sle_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   item_type cls_item;
   logic     cls_keep;
   logic     take;

   // classify; erase codes before the printable test since DEL is above the printable floor
   always_comb begin
      cls_item.data = req_rx_byte;
      cls_item.op   = OP_PUT;
      cls_keep      = 1'b1;
      priority if (req_rx_byte == CHAR_LF || req_rx_byte == CHAR_CR) begin
         cls_item.op = OP_EOL;
      end else if (req_rx_byte == CHAR_BS || req_rx_byte == CHAR_DEL) begin
         cls_item.op = OP_ERASE;
      end else if (req_rx_byte >= CHAR_PRINT_MIN) begin
         cls_item.op = OP_PUT;
      end else begin
         cls_keep = 1'b0;
      end
   end

   assign q_push    = valid_ff && !q_status.full;
   assign take      = !valid_ff || q_push;
   assign req_stall = !take;
   assign q_item    = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = req_valid && cls_keep;
         item_in  = cls_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

### src/sle_queue.sv
module sle_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sle_pkg::item_type         push_item,
   input  logic                      pop,
   output sle_pkg::item_type         pop_item,
   output sle_pkg::queue_status_type status
);
   import sle_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign pop_item     = mem_ff[rd_ptr_ff];
   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/sle_back.sv
module sle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sle_pkg::queue_status_type q_status,
   input  sle_pkg::item_type         pop_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_out_bytes,
   output logic [3:0]                rsp_out_count,
   output logic [1:0]                rsp_out_kind,
   output logic                      rsp_out_last
);
   import sle_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CMD,
      ST_GATHER,
      ST_CHUNK
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       ik_ff, ik_in;
   logic [3:0]       chunk_n_ff, chunk_n_in;
   logic             a_valid_ff, a_valid_in;
   logic [POS_W-1:0] a_pos_ff, a_pos_in;
   logic [2:0]       a_k_ff, a_k_in;
   logic [63:0]      word_ff, word_in;
   logic             mism_ff, mism_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]       rsp_count_ff, rsp_count_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic             rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        ram_q;
   logic [POS_W-1:0]  rel_pos;
   logic [POS_W-1:0]  rem;
   logic [3:0]        next_n;
   logic [2:0]        last_lane;
   logic [7:0]        msg_byte;
   logic [7:0]        cmd_byte;
   logic              mism_now;
   logic              len_has_room;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign pop          = (state_ff == ST_IDLE) && !q_status.empty && out_free;
   assign len_has_room = (len_ff < LEN_W'(LINE_CAPACITY));
   assign wr_en        = pop && (pop_item.op == OP_PUT) && len_has_room;
   assign rd_addr      = ADDR_W'(pos_ff - POS_W'(PREFIX_LEN));

   sle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CAPACITY)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (pop_item.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // byte at the collect stage
   assign rel_pos   = a_pos_ff - POS_W'(PREFIX_LEN);
   assign cmd_byte  = cmd_char(rel_pos[3:0]);
   assign mism_now  = mism_ff || (ram_q != cmd_byte);
   assign rem       = total_ff - pos_ff;
   assign next_n    = (rem >= POS_W'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : rem[3:0];
   assign last_lane = 3'(chunk_n_ff - 4'd1);

   always_comb begin
      if (a_pos_ff < POS_W'(PREFIX_LEN)) begin
         msg_byte = prefix_char(a_pos_ff[3:0]);
      end else if (a_pos_ff < POS_W'(PREFIX_LEN) + POS_W'(len_ff)) begin
         msg_byte = ram_q;
      end else begin
         msg_byte = CHAR_LF;
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      ik_in        = ik_ff;
      chunk_n_in   = chunk_n_ff;
      a_valid_in   = 1'b0;
      a_pos_in     = a_pos_ff;
      a_k_in       = a_k_ff;
      word_in      = word_ff;
      mism_in      = mism_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (pop_item.op)
                  OP_PUT: begin
                     if (len_has_room) begin
                        len_in       = len_ff + LEN_W'(1);
                        rsp_valid_in = 1'b1;
                        rsp_bytes_in = {56'd0, pop_item.data};
                        rsp_count_in = 4'd1;
                        rsp_kind_in  = KIND_ECHO;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (len_ff != '0) begin
                        len_in = len_ff - LEN_W'(1);
                     end
                  end
                  OP_EOL: begin
                     rsp_valid_in = 1'b1;
                     rsp_bytes_in = {48'd0, CHAR_LF, CHAR_CR};
                     rsp_count_in = 4'd2;
                     rsp_kind_in  = KIND_ECHO;
                     rsp_last_in  = (len_ff == '0);
                     total_in     = POS_W'(len_ff) + POS_W'(PREFIX_LEN + 1);
                     if (len_ff == LEN_W'(CMD_LEN)) begin
                        state_in = ST_CHECK;
                        pos_in   = POS_W'(PREFIX_LEN);
                        mism_in  = 1'b0;
                     end else if (len_ff != '0) begin
                        state_in   = ST_GATHER;
                        pos_in     = '0;
                        ik_in      = '0;
                        chunk_n_in = 4'(CHUNK_BYTES);
                        word_in    = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (pos_ff != POS_W'(PREFIX_LEN + CMD_LEN)) begin
               pos_in     = pos_ff + POS_W'(1);
               a_valid_in = 1'b1;
               a_pos_in   = pos_ff;
            end
            if (a_valid_ff) begin
               mism_in = mism_now;
               if (a_pos_ff == POS_W'(PREFIX_LEN + CMD_LEN - 1)) begin
                  if (!mism_now) begin
                     state_in = ST_CMD;
                  end else begin
                     state_in   = ST_GATHER;
                     pos_in     = '0;
                     ik_in      = '0;
                     chunk_n_in = 4'(CHUNK_BYTES);
                     word_in    = '0;
                  end
               end
            end
         end

         ST_CMD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bytes_in = '0;
               rsp_count_in = 4'd0;
               rsp_kind_in  = KIND_CMD;
               rsp_last_in  = 1'b1;
               len_in       = '0;
               state_in     = ST_IDLE;
            end
         end

         ST_GATHER: begin
            if (ik_ff != chunk_n_ff) begin
               pos_in     = pos_ff + POS_W'(1);
               ik_in      = ik_ff + 4'd1;
               a_valid_in = 1'b1;
               a_pos_in   = pos_ff;
               a_k_in     = ik_ff[2:0];
            end
            if (a_valid_ff) begin
               word_in[{a_k_ff, 3'b000} +: 8] = msg_byte;
               if (a_k_ff == last_lane) begin
                  state_in = ST_CHUNK;
               end
            end
         end

         ST_CHUNK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bytes_in = word_ff;
               rsp_count_in = chunk_n_ff;
               rsp_kind_in  = KIND_MSG;
               rsp_last_in  = (pos_ff == total_ff);
               if (pos_ff == total_ff) begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  chunk_n_in = next_n;
                  ik_in      = '0;
                  word_in    = '0;
                  state_in   = ST_GATHER;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff     <= total_in;
      pos_ff       <= pos_in;
      ik_ff        <= ik_in;
      chunk_n_ff   <= chunk_n_in;
      a_pos_ff     <= a_pos_in;
      a_k_ff       <= a_k_in;
      word_ff      <= word_in;
      mism_ff      <= mism_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_bytes = rsp_bytes_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_out_kind  = rsp_kind_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule
